// ===== hdl/dsv_pkg.sv =====
// Shared types and constants for the small DSA signature verifier.
// Holds the word layouts, verdict codes, register indexes and the
// request/response structs of the bit-serial modular multiplier.
package dsv_pkg;

  localparam int MOD_BITS     = 16;
  localparam int EXP_BITS     = 32;
  localparam int HASH_BITS    = 16;
  localparam int BYTE_BITS    = 8;
  localparam int HVAL_BITS    = 11;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int HASH_SHIFT   = 4;
  localparam int HASH_DIV     = 55;
  localparam int HASH_MIN     = 5;
  localparam int MOD_MIN      = 3;
  localparam int REM_BITS     = 6;
  localparam int STEP_BITS    =
      $clog2(((HASH_BITS > MOD_BITS) ? HASH_BITS : MOD_BITS) + 1);

  typedef enum logic [1:0] {
    VERDICT_VALID   = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_SKIPPED = 2'd2
  } verdict_e;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SUBGROUP_ORDER = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_PRIME    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_KEY     = 2'd3;

  typedef struct packed {
    logic [BYTE_BITS-1:0] msg_byte;
    logic                 last_byte;
    logic [MOD_BITS-1:0]  sig_r;
    logic [MOD_BITS-1:0]  sig_s;
  } in_word_t;

  typedef struct packed {
    verdict_e             verdict;
    logic [HVAL_BITS-1:0] hash_value;
  } out_word_t;

  // a must already be below m; b is scanned whole, msb first
  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
    logic [MOD_BITS-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] res;
  } mm_rsp_t;

endpackage

// ===== hdl/dsv_modmul.sv =====
// Bit-serial modular multiplier: res = a * b mod m, one bit of b per cycle.
// Depends on dsv_pkg for widths and the request/response structs.
module dsv_modmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dsv_pkg::mm_req_t req_i,
  output dsv_pkg::mm_rsp_t rsp_o
);
  import dsv_pkg::*;

  logic [MOD_BITS-1:0]  a_q, b_q, m_q, acc_q;
  logic [STEP_BITS-1:0] cnt_q;
  logic                 run_q, done_q;
  logic [MOD_BITS:0]    m_ext, dbl, dbl_red, sum, sum_red;

  // acc = (2*acc mod m + bit*a) mod m, each half stays below 2m
  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = dbl_red + (b_q[MOD_BITS-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q   <= req_i.a;
        b_q   <= req_i.b;
        m_q   <= req_i.m;
        acc_q <= '0;
        cnt_q <= STEP_BITS'(MOD_BITS);
        run_q <= 1'b1;
      end else if (run_q) begin
        acc_q <= sum_red[MOD_BITS-1:0];
        b_q   <= b_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_BITS'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("modmul started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q && $past(run_q))
    else $error("modmul done without a finished run");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q != '0)
    else $error("modmul running with an empty step count");
`endif

endmodule

// ===== hdl/small_dsa_signature_verify_core.sv =====
// Small DSA-style signature verifier: hashes a byte stream, then checks (r, s).
// Depends on dsv_pkg and dsv_modmul.
//
// Message bytes are taken one per cycle and folded into a 16-bit shift-add
// hash. The byte flagged last_byte also carries sig_r and sig_s and starts
// verification; no word is taken until it finishes. The hash is divided by
// 55 bit-serially; if the quotient is below 5 the result is "skipped" at once.
// Otherwise all modular work runs on one bit-serial multiplier: a reduction
// of s, an inverse by powering to q-2 (up to 31 multiplies), a shift-add for
// u1 and u2, two reductions and two powers over 32-bit exponents (up to 63
// multiplies each), a final multiply and a reduction mod q. The result sits
// in an output register, so the next message streams in while it waits to
// be taken.
module small_dsa_signature_verify_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dsv_pkg::CFG_IDX_BITS-1:0]     cfg_addr_i,
  input  logic [dsv_pkg::CFG_BITS-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dsv_pkg::in_word_t                    in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dsv_pkg::out_word_t                   out_word_o
);
  import dsv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_SRED = 4'd2;
  localparam logic [3:0] S_POW  = 4'd3;
  localparam logic [3:0] S_UMUL = 4'd4;
  localparam logic [3:0] S_GRED = 4'd5;
  localparam logic [3:0] S_YRED = 4'd6;
  localparam logic [3:0] S_FMUL = 4'd7;
  localparam logic [3:0] S_QRED = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] PH_MUL = 2'd0;
  localparam logic [1:0] PH_SQR = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  localparam logic [1:0] POW_W = 2'd0;
  localparam logic [1:0] POW_G = 2'd1;
  localparam logic [1:0] POW_Y = 2'd2;

  localparam logic [MOD_BITS-1:0] MOD_ONE  = MOD_BITS'(1);
  localparam logic [MOD_BITS-1:0] MOD_LOW  = MOD_BITS'(MOD_MIN);
  localparam logic [REM_BITS:0]   DIV_K    = (REM_BITS + 1)'(HASH_DIV);
  localparam logic [HVAL_BITS-1:0] H_MIN   = HVAL_BITS'(HASH_MIN);

  logic [3:0]            state_q;
  logic [1:0]            phase_q, pow_sel_q;
  logic                  launch_q;
  logic [STEP_BITS-1:0]  cnt_q;

  logic [MOD_BITS-1:0]   q_q, p_q, g_q, y_q;
  logic [HASH_BITS-1:0]  hash_q, hash_d, src_q;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [REM_BITS:0]     rem_t;
  logic                  qbit;
  logic [HVAL_BITS-1:0]  quo_q, quo_d;
  logic [MOD_BITS-1:0]   r_q, s_q, acc_q, sq_q, a_q, msr_q, pow_m, cfg_val;
  logic [EXP_BITS-1:0]   exp_q, u1_q, u2_q;
  logic                  exp_rest_zero;
  verdict_e              verdict_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  mm_req_t               mm_req;
  mm_rsp_t               mm_rsp;

  dsv_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign cfg_val = cfg_wdata_i[MOD_BITS-1:0];
  assign hash_d  = (hash_q << HASH_SHIFT) +
      {{(HASH_BITS - BYTE_BITS){in_word_i.msg_byte[BYTE_BITS-1]}}, in_word_i.msg_byte};

  // restoring divide by 55, one hash bit per cycle
  assign rem_t = {rem_q, src_q[HASH_BITS-1]};
  assign qbit  = (rem_t >= DIV_K);
  assign rem_d = qbit ? REM_BITS'(rem_t - DIV_K) : rem_t[REM_BITS-1:0];
  assign quo_d = {quo_q[HVAL_BITS-2:0], qbit};

  assign pow_m         = (pow_sel_q == POW_W) ? q_q : p_q;
  assign exp_rest_zero = (exp_q[EXP_BITS-1:1] == '0);

  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = MOD_ONE;
    mm_req.b     = s_q;
    mm_req.m     = q_q;
    case (state_q)
      S_SRED: begin
        mm_req.start = launch_q;
      end
      S_POW: begin
        mm_req.m = pow_m;
        mm_req.b = sq_q;
        if (phase_q == PH_MUL) begin
          mm_req.a     = acc_q;
          mm_req.start = launch_q && exp_q[0];
        end else if (phase_q == PH_SQR) begin
          mm_req.a     = sq_q;
          mm_req.start = launch_q;
        end
      end
      S_GRED: begin
        mm_req.start = launch_q;
        mm_req.b     = g_q;
        mm_req.m     = p_q;
      end
      S_YRED: begin
        mm_req.start = launch_q;
        mm_req.b     = y_q;
        mm_req.m     = p_q;
      end
      S_FMUL: begin
        mm_req.start = launch_q;
        mm_req.a     = a_q;
        mm_req.b     = acc_q;
        mm_req.m     = p_q;
      end
      S_QRED: begin
        mm_req.start = launch_q;
        mm_req.b     = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_MUL;
      pow_sel_q   <= POW_W;
      launch_q    <= 1'b0;
      cnt_q       <= '0;
      q_q         <= MOD_LOW;
      p_q         <= MOD_LOW;
      g_q         <= '0;
      y_q         <= '0;
      hash_q      <= '0;
      src_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      r_q         <= '0;
      s_q         <= '0;
      acc_q       <= MOD_ONE;
      sq_q        <= '0;
      a_q         <= '0;
      msr_q       <= '0;
      exp_q       <= '0;
      u1_q        <= '0;
      u2_q        <= '0;
      verdict_q   <= VERDICT_VALID;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drop the taken word unless a new result replaces it
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SUBGROUP_ORDER: q_q <= (cfg_val < MOD_LOW) ? MOD_LOW : cfg_val;
          CFG_FIELD_PRIME:    p_q <= (cfg_val < MOD_LOW) ? MOD_LOW : cfg_val;
          CFG_GENERATOR:      g_q <= cfg_val;
          CFG_PUBLIC_KEY:     y_q <= cfg_val;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_word_i.last_byte) begin
              hash_q  <= '0;
              src_q   <= hash_d;
              rem_q   <= '0;
              quo_q   <= '0;
              cnt_q   <= STEP_BITS'(HASH_BITS);
              r_q     <= in_word_i.sig_r;
              s_q     <= in_word_i.sig_s;
              state_q <= S_DIV;
            end else begin
              hash_q <= hash_d;
            end
          end
        end
        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          src_q <= src_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == STEP_BITS'(1)) begin
            verdict_q <= VERDICT_SKIPPED;
            launch_q  <= 1'b1;
            state_q   <= (quo_d < H_MIN) ? S_OUT : S_SRED;
          end
        end
        S_SRED: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mm_rsp.done) begin
            sq_q      <= mm_rsp.res;
            acc_q     <= MOD_ONE;
            exp_q     <= EXP_BITS'(q_q - MOD_BITS'(2));
            pow_sel_q <= POW_W;
            phase_q   <= PH_MUL;
            launch_q  <= 1'b1;
            state_q   <= S_POW;
          end
        end
        S_POW: begin
          case (phase_q)
            PH_MUL: begin
              if (launch_q) begin
                if (exp_q == '0) begin
                  phase_q <= PH_FIN;
                end else if (!exp_q[0]) begin
                  // skip the multiply for a clear exponent bit
                  phase_q <= exp_rest_zero ? PH_FIN : PH_SQR;
                end else begin
                  launch_q <= 1'b0;
                end
              end else if (mm_rsp.done) begin
                acc_q    <= mm_rsp.res;
                launch_q <= 1'b1;
                phase_q  <= exp_rest_zero ? PH_FIN : PH_SQR;
              end
            end
            PH_SQR: begin
              if (launch_q) begin
                launch_q <= 1'b0;
              end else if (mm_rsp.done) begin
                sq_q     <= mm_rsp.res;
                exp_q    <= exp_q >> 1;
                launch_q <= 1'b1;
                phase_q  <= PH_MUL;
              end
            end
            PH_FIN: begin
              launch_q <= 1'b1;
              phase_q  <= PH_MUL;
              case (pow_sel_q)
                POW_W: begin
                  msr_q   <= acc_q;
                  u1_q    <= '0;
                  u2_q    <= '0;
                  cnt_q   <= STEP_BITS'(MOD_BITS);
                  state_q <= S_UMUL;
                end
                POW_G: begin
                  a_q     <= acc_q;
                  state_q <= S_YRED;
                end
                POW_Y: begin
                  state_q <= S_FMUL;
                end
                default: begin
                  state_q <= S_IDLE;
                end
              endcase
            end
            default: begin
              phase_q <= PH_MUL;
            end
          endcase
        end
        S_UMUL: begin
          // u1 = H*w and u2 = r*w, shift-add over the bits of w
          u1_q  <= (u1_q << 1) + (msr_q[MOD_BITS-1] ? EXP_BITS'(quo_q) : '0);
          u2_q  <= (u2_q << 1) + (msr_q[MOD_BITS-1] ? EXP_BITS'(r_q) : '0);
          msr_q <= msr_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == STEP_BITS'(1)) begin
            launch_q <= 1'b1;
            state_q  <= S_GRED;
          end
        end
        S_GRED: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mm_rsp.done) begin
            sq_q      <= mm_rsp.res;
            acc_q     <= MOD_ONE;
            exp_q     <= u1_q;
            pow_sel_q <= POW_G;
            phase_q   <= PH_MUL;
            launch_q  <= 1'b1;
            state_q   <= S_POW;
          end
        end
        S_YRED: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mm_rsp.done) begin
            sq_q      <= mm_rsp.res;
            acc_q     <= MOD_ONE;
            exp_q     <= u2_q;
            pow_sel_q <= POW_Y;
            phase_q   <= PH_MUL;
            launch_q  <= 1'b1;
            state_q   <= S_POW;
          end
        end
        S_FMUL: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mm_rsp.done) begin
            acc_q    <= mm_rsp.res;
            launch_q <= 1'b1;
            state_q  <= S_QRED;
          end
        end
        S_QRED: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mm_rsp.done) begin
            verdict_q <= (mm_rsp.res == r_q) ? VERDICT_VALID : VERDICT_INVALID;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.verdict    <= verdict_q;
            out_q.hash_value <= quo_q;
            launch_q         <= 1'b0;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.last_byte |=> state_q == S_DIV)
    else $error("last word did not start verification");

  a_skip_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.verdict == VERDICT_SKIPPED |->
      out_word_o.hash_value < H_MIN)
    else $error("skipped verdict with a large hash");

  a_check_large: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.verdict != VERDICT_SKIPPED |->
      out_word_o.hash_value >= H_MIN)
    else $error("checked verdict with a small hash");
`endif

endmodule
